/* hw/rtl/sog_pkg.sv */
// Package: shared types, constants and sine table function for the glide oscillator
`default_nettype none
package sog_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int MAX_BLOCK_LENGTH_DEF = 4096;
  localparam logic [30:0] INC_RESET = 31'd48695839;
  localparam logic [14:0] GAIN_RESET = 15'd8192;
  localparam logic [12:0] LEN_RESET = 13'd512;
  localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN   = 3'd1,
    REG_MODE   = 3'd2,
    REG_MUTE   = 3'd3,
    REG_LEN    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NAIVE  = 2'd0,
    MODE_GLIDE  = 2'd1,
    MODE_EFFECT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOOK,
    ST_GAIN,
    ST_OUT
  } state_t;

  // Quarter-wave entry i, evaluated at elaboration only (constant argument).
  // depth is a power of two; the Taylor terms run to x^13.
  function automatic logic [15:0] quarter_entry(input int i, input int depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint v;
    begin
      x = (PIHALF_Q30 * (64'(2 * i + 1))) >> ($clog2(depth) + 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      if (sum <= 0) v = 0;
      else v = longint'(((64'(sum) * 64'd32767) + 64'd536870912) >> 30);
      if (v > 32767) v = 32767;
      quarter_entry = 16'(v);
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sog_divider.sv */
// Radix-2 restoring divider: signed 33-bit dividend over a positive length
`default_nettype none
module sog_divider
  import sog_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] dividend,   // two's complement
  input  wire logic [12:0] divisor,    // 1..4096
  output logic             done,
  output logic [31:0]      quotient    // truncated toward zero, low 32 bits
);
  logic [32:0] quo_r, quo_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic [12:0] dvs_r, dvs_nxt;
  logic [14:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    trial    = '0;
    done     = 1'b0;
    if (start) begin
      neg_nxt  = dividend[32];
      quo_nxt  = dividend[32] ? (~dividend + 33'd1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != 6'd0) begin
        trial = {rem_r, quo_r[32]} - {2'b00, dvs_r};
        if (!trial[14]) rem_nxt = trial[13:0];
        else rem_nxt = {rem_r[12:0], quo_r[32]};
        quo_nxt = {quo_r[31:0], ~trial[14]};
        cnt_nxt = cnt_r - 6'd1;
      end else begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign quotient = neg_r ? (~quo_r[31:0] + 32'd1) : quo_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
  end
endmodule
`default_nettype wire

/* hw/rtl/sine_oscillator_with_glide_unit.sv */
// Top level: phase-accumulator sine oscillator with glide, sequenced datapath
// Each beat runs ST_MUL, ST_LOOK, ST_GAIN, ST_OUT; muted or mode-unused beats go
// straight to ST_OUT; a glide or effect block start runs the shared divider first.
// The sequencer holds one beat at a time: the next beat is taken the cycle after
// the result leaves.
// Reset (rst_n, synchronous, active low) restores config, sequencer and oscillator
// state to their defaults; the sine table is constant logic and needs no fill.
`default_nettype none
module sine_oscillator_with_glide_unit
  import sog_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int MAX_BLOCK_LENGTH = MAX_BLOCK_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] start_block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] sample
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);
  localparam int IW = $clog2(SINE_TABLE_DEPTH);

  // Constant quarter-wave table
  logic [15:0] quarter [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    assign quarter[g] = quarter_entry(g, SINE_TABLE_DEPTH);
  end

  // Configuration
  logic [30:0] target_r;
  logic [14:0] gain_r;
  logic [1:0]  mode_r;
  logic        mute_r;
  logic [12:0] blen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= INC_RESET;
      gain_r   <= GAIN_RESET;
      mode_r   <= MODE_NAIVE;
      mute_r   <= 1'b0;
      blen_r   <= LEN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET: target_r <= cfg_wdata;
        REG_GAIN:   gain_r   <= cfg_wdata[14:0];
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_MUTE:   mute_r   <= cfg_wdata[0];
        REG_LEN:    blen_r   <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Effective block length, clamped to 1..MAX_BLOCK_LENGTH
  logic [12:0] len;
  always_comb begin
    if (blen_r == 13'd0) len = 13'd1;
    else if (32'(blen_r) > 32'(MAX_BLOCK_LENGTH)) len = 13'(MAX_BLOCK_LENGTH);
    else len = blen_r;
  end

  // Oscillator state
  logic [31:0] phase_r, phase_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] step_r, step_nxt;
  logic [31:0] lat_r, lat_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [12:0] pos_r, pos_nxt;

  // Datapath registers
  state_t      st_r, st_nxt;
  logic        active_r, active_nxt;
  logic        apply_r, apply_nxt;
  logic [31:0] ph_r, ph_nxt;
  logic [15:0] raw_r, raw_nxt;      // signed Q0.15
  logic [15:0] res_r, res_nxt;
  logic [29:0] prod_r, prod_nxt;

  // Shared divider; the step is taken against the newly latched target
  logic        div_start, div_done;
  logic [31:0] div_q;
  sog_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({2'b00, target_r} - {1'b0, cur_r}),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sine lookup from captured phase
  logic [1:0]    quad;
  logic [IW-1:0] idx;
  logic [15:0]   mag;
  assign quad = ph_r[31:30];
  assign idx  = quad[0] ? ~ph_r[29:30-IW] : ph_r[29:30-IW];
  assign mag  = quarter[idx];

  // Gain stage operands
  logic [15:0] amag;
  logic [30:0] mulp;
  logic [16:0] p;
  assign amag = raw_r[15] ? (~raw_r + 16'd1) : raw_r;
  assign mulp = amag * gain_r;
  assign p    = 17'((31'(prod_r) + 31'd8192) >> 14);

  logic        last;
  assign last = (32'(pos_r) + 32'd1) >= 32'(len);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        if (mute_r || mode_r == MODE_NONE) st_nxt = ST_OUT;
        else if (in_tdata[0] && mode_r != MODE_NAIVE) st_nxt = ST_DIV;
        else st_nxt = ST_MUL;
      end
      ST_DIV:  if (div_done) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_LOOK;
      ST_LOOK: st_nxt = ST_GAIN;
      ST_GAIN: st_nxt = ST_OUT;
      ST_OUT:  if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r; cur_nxt = cur_r; step_nxt = step_r;
    lat_nxt = lat_r; cnt_nxt = cnt_r; pos_nxt = pos_r;
    active_nxt = active_r; apply_nxt = apply_r;
    ph_nxt = ph_r; raw_nxt = raw_r; res_nxt = res_r; prod_nxt = prod_r;
    div_start = 1'b0;
    in_tready = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_OUT);
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        active_nxt = !(mute_r || mode_r == MODE_NONE);
        res_nxt    = '0;
        if (!(mute_r || mode_r == MODE_NONE) && in_tdata[0]) begin
          lat_nxt = {1'b0, target_r};
          pos_nxt = '0;
          if (mode_r == MODE_NAIVE) step_nxt = '0;
          else div_start = 1'b1;
        end
      end
      ST_DIV: if (div_done) begin
        step_nxt = div_q;
        if (mode_r == MODE_EFFECT) phase_nxt = cur_r;
      end
      ST_MUL: begin
        if (mode_r == MODE_NAIVE) begin
          ph_nxt = lat_r * cnt_r;
          apply_nxt = 1'b1;
        end else begin
          ph_nxt = phase_r;
          apply_nxt = (mode_r == MODE_GLIDE) || (cur_r != lat_r);
          if (last) begin
            cur_nxt = lat_r;
            step_nxt = '0;
            phase_nxt = phase_r + lat_r;
          end else begin
            cur_nxt = cur_r + step_r;
            phase_nxt = phase_r + cur_r + step_r;
          end
        end
        if (!last) pos_nxt = pos_r + 13'd1;
        else pos_nxt = len - 13'd1;
        cnt_nxt = cnt_r + 32'd1;
      end
      ST_LOOK: raw_nxt = quad[1] ? (~mag + 16'd1) : mag;
      ST_GAIN: begin
        prod_nxt = mulp[29:0];
        res_nxt = raw_r;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Final gain rounding and saturation, computed combinationally on the output path
  logic [15:0] gained;
  always_comb begin
    if (raw_r[15]) gained = (p > 17'd32768) ? 16'h8000 : 16'(~p + 17'd1);
    else gained = (p > 17'd32767) ? 16'h7FFF : p[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      phase_r <= '0; cur_r <= {1'b0, INC_RESET}; step_r <= '0;
      lat_r <= {1'b0, INC_RESET}; cnt_r <= '0; pos_r <= '0;
      active_r <= 1'b0; apply_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      phase_r <= phase_nxt; cur_r <= cur_nxt; step_r <= step_nxt;
      lat_r <= lat_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt;
      active_r <= active_nxt; apply_r <= apply_nxt;
    end
    ph_r <= ph_nxt; raw_r <= raw_nxt; prod_r <= prod_nxt;
    res_r <= res_nxt;
  end

  // Output: zero when muted or mode unused, raw when gain skipped, else gained result.
  // prod_r is settled by the time ST_OUT is reached.
  assign out_tdata = !active_r ? 16'd0 : (apply_r ? gained : res_r);
endmodule
`default_nettype wire
